### design/mlrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlrt_pkg;

	// widths of the beat fields
	localparam int ID_W   = 4;
	localparam int LIST_W = 2;

	// default pool shape
	localparam int DEF_ENTRIES = 16;
	localparam int DEF_LISTS   = 4;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_LINK,
		ST_INS,
		ST_SELF,
		ST_LAST,
		ST_DONE
	} state_t;

	// contents of a store entry before its first write
	typedef enum logic [1:0] {
		INIT_NEXT,
		INIT_PREV,
		INIT_CONST
	} init_mode_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic capture;
		logic look;
		logic take_last;
		logic link;
		logic ins;
		logic self_link;
		logic load_out;
	} cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic ok;
		logic ok_q;
	} dp_status_t;

endpackage

`default_nettype wire

### design/mlrt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mlrt_ram #(
	parameter int                  DEPTH      = mlrt_pkg::DEF_ENTRIES,
	parameter int                  WIDTH      = 4,
	parameter mlrt_pkg::init_mode_t INIT_MODE = mlrt_pkg::INIT_NEXT,
	parameter int                  INIT_VALUE = 0
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvld_q;
	logic [AW-1:0]    raddr_q;
	logic [WIDTH-1:0] init_val;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
		raddr_q <= raddr;
	end

	// per-entry written flags, so reset needs no clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	always_comb begin
		case (INIT_MODE)
			mlrt_pkg::INIT_NEXT:
				init_val = (raddr_q == AW'(DEPTH - 1)) ? '0 : WIDTH'(raddr_q + AW'(1));
			mlrt_pkg::INIT_PREV:
				init_val = (raddr_q == '0) ? WIDTH'(AW'(DEPTH - 1)) : WIDTH'(raddr_q - AW'(1));
			default:
				init_val = WIDTH'(INIT_VALUE);
		endcase
	end

	assign rdata = rvld_q ? rdata_q : init_val;

endmodule

`default_nettype wire

### design/mlrt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mlrt_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire mlrt_pkg::dp_status_t st,
	output mlrt_pkg::cmd_t            cmd
);

	mlrt_pkg::state_t state_q;
	mlrt_pkg::state_t state_d;
	logic             out_valid_q;
	logic             slot_free;

	// result register empties or hands over its beat this edge
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mlrt_pkg::ST_IDLE: if (in_valid) state_d = mlrt_pkg::ST_LOOK;
			mlrt_pkg::ST_LOOK: state_d = st.ok ? mlrt_pkg::ST_LINK : mlrt_pkg::ST_LAST;
			mlrt_pkg::ST_LINK: state_d = mlrt_pkg::ST_INS;
			mlrt_pkg::ST_INS:  state_d = mlrt_pkg::ST_SELF;
			mlrt_pkg::ST_SELF: state_d = mlrt_pkg::ST_DONE;
			mlrt_pkg::ST_LAST: state_d = mlrt_pkg::ST_DONE;
			mlrt_pkg::ST_DONE: if (slot_free) state_d = mlrt_pkg::ST_IDLE;
			default:           state_d = mlrt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			mlrt_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			mlrt_pkg::ST_LOOK: cmd.look = 1'b1;
			mlrt_pkg::ST_LINK: begin
				cmd.link      = 1'b1;
				cmd.take_last = 1'b1;
			end
			mlrt_pkg::ST_INS:  cmd.ins = 1'b1;
			mlrt_pkg::ST_SELF: cmd.self_link = 1'b1;
			mlrt_pkg::ST_LAST: cmd.take_last = 1'b1;
			mlrt_pkg::ST_DONE: cmd.load_out = slot_free;
			default:           cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mlrt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### design/mlrt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module mlrt_dpath #(
	parameter int ENTRIES = mlrt_pkg::DEF_ENTRIES,
	parameter int LISTS   = mlrt_pkg::DEF_LISTS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mlrt_pkg::cmd_t              cmd,
	output mlrt_pkg::dp_status_t             st,
	input  wire logic [mlrt_pkg::ID_W-1:0]   entry_id,
	input  wire logic [mlrt_pkg::LIST_W-1:0] source_list,
	input  wire logic [mlrt_pkg::LIST_W-1:0] dest_list,
	output logic                             status,
	output logic      [mlrt_pkg::ID_W-1:0]   dest_first,
	output logic      [mlrt_pkg::ID_W-1:0]   dest_last,
	output logic                             source_empty,
	output logic      [mlrt_pkg::ID_W-1:0]   source_first
);

	localparam int IW = $clog2(ENTRIES);
	localparam int LW = $clog2(LISTS);

	// incoming beat, range checked and folded to index width
	logic          ent_ok_in, src_ok_in, dst_ok_in;
	logic [IW-1:0] e_idx_in;
	logic [LW-1:0] src_idx_in, dst_idx_in;

	assign ent_ok_in  = 32'(entry_id) < 32'(ENTRIES);
	assign src_ok_in  = 32'(source_list) < 32'(LISTS);
	assign dst_ok_in  = 32'(dest_list) < 32'(LISTS);
	assign e_idx_in   = ent_ok_in ? IW'(entry_id) : '0;
	assign src_idx_in = src_ok_in ? LW'(source_list) : '0;
	assign dst_idx_in = dst_ok_in ? LW'(dest_list) : '0;

	// latched item
	logic          ent_ok_q, src_ok_q, dst_ok_q;
	logic [IW-1:0] e_q;
	logic [LW-1:0] src_q, dst_q;

	// values gathered in the look cycle
	logic          ok_q, fv_q, was_head_q, dv_q, sv_q;
	logic [IW-1:0] p_q, s_q, f_q, l_q, dfirst_q, sfirst_q;

	// list heads
	logic [IW-1:0]    head_mem [LISTS];
	logic [LISTS-1:0] head_valid_q;
	logic [IW-1:0]    hs_rd_q, hd_rd_q;
	logic             head_we;
	logic [LW-1:0]    head_waddr;
	logic [IW-1:0]    head_wdata;

	// pointer and owner stores
	logic          succ_we, pred_we, own_we;
	logic [IW-1:0] succ_waddr, succ_wdata, pred_waddr, pred_wdata, pred_raddr;
	logic [IW-1:0] succ_rd, pred_rd;
	logic [LW-1:0] own_rd;

	// look cycle logic
	logic          hvs, hvd, ok, was_head, hvs_n, same, fv;
	logic [IW-1:0] hs_n, f, hd_g;

	assign hvs      = src_ok_q && head_valid_q[src_q];
	assign hvd      = dst_ok_q && head_valid_q[dst_q];
	assign ok       = ent_ok_q && src_ok_q && dst_ok_q && (own_rd == src_q);
	assign was_head = hvs && (hs_rd_q == e_q);
	assign hvs_n    = hvs && !(was_head && (succ_rd == e_q));
	assign hs_n     = was_head ? succ_rd : hs_rd_q;
	assign same     = src_q == dst_q;
	assign fv       = same ? hvs_n : hvd;
	assign f        = fv ? (same ? hs_n : hd_rd_q) : '0;
	assign hd_g     = hvd ? hd_rd_q : '0;

	assign st.ok   = ok;
	assign st.ok_q = ok_q;

	always_comb begin
		if (cmd.capture) begin
			pred_raddr = e_idx_in;
		end else if (cmd.look) begin
			pred_raddr = ok ? f : hd_g;
		end else begin
			pred_raddr = e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ent_ok_q <= ent_ok_in;
			src_ok_q <= src_ok_in;
			dst_ok_q <= dst_ok_in;
			e_q      <= e_idx_in;
			src_q    <= src_idx_in;
			dst_q    <= dst_idx_in;
		end
		if (cmd.look) begin
			ok_q       <= ok;
			p_q        <= pred_rd;
			s_q        <= succ_rd;
			f_q        <= f;
			fv_q       <= fv;
			was_head_q <= was_head;
			dv_q       <= ok || hvd;
			dfirst_q   <= ok ? e_q : hd_rd_q;
			sv_q       <= ok ? (same || hvs_n) : hvs;
			sfirst_q   <= ok ? (same ? e_q : hs_n) : hs_rd_q;
		end
		// last entry of the destination ahead of insertion
		if (cmd.take_last) begin
			l_q <= (ok_q && f_q == s_q) ? p_q : pred_rd;
		end
		if (cmd.load_out) begin
			status       <= !ok_q;
			dest_first   <= dv_q ? mlrt_pkg::ID_W'(dfirst_q) : '0;
			dest_last    <= !dv_q ? '0 :
			                (ok_q && !fv_q) ? mlrt_pkg::ID_W'(e_q) : mlrt_pkg::ID_W'(l_q);
			source_empty <= !sv_q;
			source_first <= sv_q ? mlrt_pkg::ID_W'(sfirst_q) : '0;
		end
	end

	// head writes: advance on removal, new first entry on insertion
	always_comb begin
		head_we    = 1'b0;
		head_waddr = src_q;
		head_wdata = s_q;
		if (cmd.link && was_head_q && (s_q != e_q)) begin
			head_we = 1'b1;
		end else if (cmd.ins) begin
			head_we    = 1'b1;
			head_waddr = dst_q;
			head_wdata = e_q;
		end
	end

	// heads start at entry zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				head_mem[i] <= '0;
			end
		end else if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
	end

	always_ff @(posedge clk) begin
		hs_rd_q <= head_mem[src_idx_in];
		hd_rd_q <= head_mem[dst_idx_in];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= {1'b1, {(LISTS-1){1'b0}}};
		end else begin
			if (cmd.link && was_head_q && (s_q == e_q)) begin
				head_valid_q[src_q] <= 1'b0;
			end
			if (cmd.ins) begin
				head_valid_q[dst_q] <= 1'b1;
			end
		end
	end

	// unlink, splice in ahead of the old first entry, then close the entry
	always_comb begin
		succ_we    = 1'b0;
		succ_waddr = p_q;
		succ_wdata = s_q;
		pred_we    = 1'b0;
		pred_waddr = s_q;
		pred_wdata = p_q;
		if (cmd.link) begin
			succ_we = 1'b1;
			pred_we = 1'b1;
		end else if (cmd.ins) begin
			succ_we    = fv_q;
			succ_waddr = l_q;
			succ_wdata = e_q;
			pred_we    = fv_q;
			pred_waddr = f_q;
			pred_wdata = e_q;
		end else if (cmd.self_link) begin
			succ_we    = 1'b1;
			succ_waddr = e_q;
			succ_wdata = fv_q ? f_q : e_q;
			pred_we    = 1'b1;
			pred_waddr = e_q;
			pred_wdata = fv_q ? l_q : e_q;
		end
	end

	assign own_we = cmd.link;

	mlrt_ram #(
		.DEPTH      (ENTRIES),
		.WIDTH      (IW),
		.INIT_MODE  (mlrt_pkg::INIT_NEXT),
		.INIT_VALUE (0)
	) u_succ (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (succ_we),
		.waddr (succ_waddr),
		.wdata (succ_wdata),
		.raddr (e_idx_in),
		.rdata (succ_rd)
	);

	mlrt_ram #(
		.DEPTH      (ENTRIES),
		.WIDTH      (IW),
		.INIT_MODE  (mlrt_pkg::INIT_PREV),
		.INIT_VALUE (0)
	) u_pred (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (pred_we),
		.waddr (pred_waddr),
		.wdata (pred_wdata),
		.raddr (pred_raddr),
		.rdata (pred_rd)
	);

	mlrt_ram #(
		.DEPTH      (ENTRIES),
		.WIDTH      (LW),
		.INIT_MODE  (mlrt_pkg::INIT_CONST),
		.INIT_VALUE (LISTS - 1)
	) u_owner (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (own_we),
		.waddr (e_q),
		.wdata (dst_q),
		.raddr (e_idx_in),
		.rdata (own_rd)
	);

endmodule

`default_nettype wire

### design/multi_list_ring_transfer.sv
`timescale 1ns / 1ps
`default_nettype none

// list mover for a fixed pool of ENTRIES entries, each held in exactly one of LISTS circular
// doubly linked lists with a first-entry pointer per list; at reset every entry sits in the
// last list in index order. each input beat names an entry, a source list and a destination
// list: the entry is unlinked from the source (its head advances or empties) and spliced in
// ahead of the destination's old first entry, becoming its new first entry. an entry that is
// not in the named source, or an index out of range, gives status 1 and changes nothing.
// each input beat gives one result beat. items are handled one at a time, and a move steps
// through unlink, splice and self-close in turn after its look-up, as the successor and
// predecessor stores each have a single write port; a rejected beat skips those steps.
// the result register holds a finished beat while the next one is accepted. the stores carry
// per-entry written flags, so the block is ready straight out of reset with no clearing pass.

module multi_list_ring_transfer #(
	parameter int ENTRIES = mlrt_pkg::DEF_ENTRIES,
	parameter int LISTS   = mlrt_pkg::DEF_LISTS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input beat
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [mlrt_pkg::ID_W-1:0]   entry_id,
	input  wire logic [mlrt_pkg::LIST_W-1:0] source_list,
	input  wire logic [mlrt_pkg::LIST_W-1:0] dest_list,
	// result beat
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             status,
	output logic      [mlrt_pkg::ID_W-1:0]   dest_first,
	output logic      [mlrt_pkg::ID_W-1:0]   dest_last,
	output logic                             source_empty,
	output logic      [mlrt_pkg::ID_W-1:0]   source_first
);

	// sequencer commands and datapath status
	mlrt_pkg::cmd_t       cmd;
	mlrt_pkg::dp_status_t st;

	// sequencer: accept, look up, unlink, splice, self-close, deliver (a rejected beat skips the list updates)
	mlrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// pointer stores, list heads and the result register
	mlrt_dpath #(
		.ENTRIES(ENTRIES),
		.LISTS  (LISTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.entry_id    (entry_id),
		.source_list (source_list),
		.dest_list   (dest_list),
		.status      (status),
		.dest_first  (dest_first),
		.dest_last   (dest_last),
		.source_empty(source_empty),
		.source_first(source_first)
	);

`ifndef ASSERT_OFF
	// the sequencer issues one phase command at a time (take_last rides along with link)
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.look, cmd.link, cmd.ins, cmd.self_link, cmd.load_out}))
		else $error("more than one sequencer command at once");

	// pointer and head writes only for an item that passed the ownership check
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.link || cmd.ins || cmd.self_link) |-> st.ok_q)
		else $error("list update for a rejected item");

	// a waiting result beat is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result register loaded while a stalled beat waits");

	// an accepted beat is looked up on the next cycle
	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> cmd.look)
		else $error("accepted beat not looked up");
`endif

endmodule

`default_nettype wire
